FILE: hw/rtl/lscc_pkg.sv
// Shared types and constants of the line sensor colour classifier.
// No dependencies; imported by every module of the block.
package lscc_pkg;

  localparam int MAXCH      = 4;
  localparam int SAMPLE_W   = 10;
  localparam int MARGIN_W   = 9;
  localparam int SUM_W      = 15;
  localparam int QDEPTH     = 4;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = 10'd1000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 10'd1023;

  localparam logic [SAMPLE_W-1:0] LOWER_RESET [MAXCH] = '{10'd229, 10'd142, 10'd119, 10'd125};
  localparam logic [SAMPLE_W-1:0] UPPER_RESET [MAXCH] = '{10'd600, 10'd550, 10'd440, 10'd440};

  localparam logic [MARGIN_W-1:0] LOWER_MARGIN_RESET = 9'd51;
  localparam logic [MARGIN_W-1:0] UPPER_MARGIN_RESET = 9'd77;

  // register index, taken from paddr[2]
  localparam logic REG_LOWER_MARGIN = 1'b0;
  localparam logic REG_UPPER_MARGIN = 1'b1;

  localparam logic [1:0] COLOR_BLACK = 2'd0;
  localparam logic [1:0] COLOR_RED   = 2'd1;
  localparam logic [1:0] COLOR_WHITE = 2'd2;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_BLACK  = 2'd1,
    MODE_WHITE  = 2'd2,
    MODE_THRESH = 2'd3
  } mode_t;

  // state seen by one word after its own update
  typedef struct packed {
    logic [MAXCH-1:0][SAMPLE_W-1:0] newest;
    logic [MAXCH-1:0][SAMPLE_W-1:0] lower;
    logic [MAXCH-1:0][SAMPLE_W-1:0] upper;
    logic [MAXCH-1:0][SUM_W-1:0]    sum;
  } snap_t;

  typedef struct packed {
    logic  valid;
    snap_t data;
  } push_t;

endpackage

FILE: hw/rtl/lscc_front.sv
// Front end: accepts input words, updates ring, sums, extremes and thresholds,
// and pushes the post-update state snapshot. Depends on lscc_pkg.
module lscc_front #(
  parameter int WINDOW   = 20,
  parameter int CHANNELS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lscc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [lscc_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic [lscc_pkg::MARGIN_W-1:0]   lower_margin,
  input  logic [lscc_pkg::MARGIN_W-1:0]   upper_margin,
  input  logic                            q_full,
  output lscc_pkg::push_t                 push
);
  import lscc_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WORD_W = MAXCH * SAMPLE_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [SUM_W-1:0]  SUM_RESET = SUM_W'(WINDOW * 1000);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] x);
    slot_inc = (x == SLOT_LAST) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp10(input logic signed [12:0] v);
    if (v < 0) clamp10 = '0;
    else if (v > 13'sd1023) clamp10 = SAMPLE_MAX;
    else clamp10 = v[SAMPLE_W-1:0];
  endfunction

  mode_t               mode;
  logic                acc;
  logic                wr_en;
  logic [WORD_W-1:0]   word;
  logic [SLOT_W-1:0]   ws;
  logic [SLOT_W-1:0]   rs;

  logic [SLOT_W-1:0]   wslot_r;
  logic [WINDOW-1:0]   valid_r;
  logic                ev_ok_r;
  logic [WORD_W-1:0]   ev_r;
  logic [WORD_W-1:0]   ring_mem [WINDOW];

  logic [SAMPLE_W-1:0] newest_r [MAXCH];
  logic [SAMPLE_W-1:0] newest_nxt [MAXCH];
  logic [SUM_W-1:0]    sum_r [MAXCH];
  logic [SUM_W-1:0]    sum_nxt [MAXCH];
  logic [SAMPLE_W-1:0] bmax_r [MAXCH];
  logic [SAMPLE_W-1:0] bmax_nxt [MAXCH];
  logic [SAMPLE_W-1:0] wmin_r [MAXCH];
  logic [SAMPLE_W-1:0] wmin_nxt [MAXCH];
  logic [SAMPLE_W-1:0] lo_r [MAXCH];
  logic [SAMPLE_W-1:0] lo_nxt [MAXCH];
  logic [SAMPLE_W-1:0] hi_r [MAXCH];
  logic [SAMPLE_W-1:0] hi_nxt [MAXCH];

  assign mode      = mode_t'(in_tuser[1:0]);
  assign in_tready = !q_full;
  assign acc       = in_tvalid && !q_full;
  assign wr_en     = acc && (mode == MODE_SAMPLE);
  assign word      = in_tdata[WORD_W-1:0];
  assign ws        = slot_inc(wslot_r);
  assign rs        = slot_inc(ws);

  always_comb begin
    logic [SAMPLE_W-1:0]       s;
    logic [SAMPLE_W-1:0]       ev;
    logic signed [10:0]        span;
    logic signed [20:0]        plo;
    logic signed [20:0]        phi;
    logic signed [12:0]        tlo;
    logic signed [12:0]        thi;
    push.valid = acc;
    push.data  = '0;
    for (int c = 0; c < MAXCH; c++) begin
      s    = word[c*SAMPLE_W +: SAMPLE_W];
      ev   = ev_ok_r ? ev_r[c*SAMPLE_W +: SAMPLE_W] : SAMPLE_RESET;
      span = $signed({1'b0, wmin_r[c]}) - $signed({1'b0, bmax_r[c]});
      plo  = $signed({1'b0, lower_margin}) * span;
      phi  = $signed({1'b0, upper_margin}) * span;
      // arithmetic shift floors the Q8 product
      tlo  = $signed({3'b000, bmax_r[c]}) + plo[20:8];
      thi  = $signed({3'b000, wmin_r[c]}) - phi[20:8];
      newest_nxt[c] = newest_r[c];
      sum_nxt[c]    = sum_r[c];
      bmax_nxt[c]   = bmax_r[c];
      wmin_nxt[c]   = wmin_r[c];
      lo_nxt[c]     = lo_r[c];
      hi_nxt[c]     = hi_r[c];
      if (acc && (c < CHANNELS)) begin
        case (mode)
          MODE_SAMPLE: begin
            newest_nxt[c] = s;
            sum_nxt[c]    = sum_r[c] - SUM_W'(ev) + SUM_W'(s);
          end
          MODE_BLACK: begin
            if (s > bmax_r[c]) bmax_nxt[c] = s;
          end
          MODE_WHITE: begin
            if (s < wmin_r[c]) wmin_nxt[c] = s;
          end
          MODE_THRESH: begin
            lo_nxt[c] = clamp10(tlo);
            hi_nxt[c] = clamp10(thi);
          end
          default: ;
        endcase
      end
      push.data.newest[c] = newest_nxt[c];
      push.data.lower[c]  = lo_nxt[c];
      push.data.upper[c]  = hi_nxt[c];
      push.data.sum[c]    = sum_nxt[c];
    end
  end

  // ring store; prefetches the entry the next sample word will evict
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[ws] <= word;
      ev_r         <= (rs == ws) ? word : ring_mem[rs];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r <= SLOT_LAST;
      valid_r <= '0;
      ev_ok_r <= 1'b0;
      for (int c = 0; c < MAXCH; c++) begin
        newest_r[c] <= SAMPLE_RESET;
        sum_r[c]    <= SUM_RESET;
        bmax_r[c]   <= '0;
        wmin_r[c]   <= SAMPLE_MAX;
        lo_r[c]     <= LOWER_RESET[c];
        hi_r[c]     <= UPPER_RESET[c];
      end
    end else begin
      if (wr_en) begin
        wslot_r     <= ws;
        valid_r[ws] <= 1'b1;
        ev_ok_r     <= (rs == ws) ? 1'b1 : valid_r[rs];
      end
      for (int c = 0; c < MAXCH; c++) begin
        newest_r[c] <= newest_nxt[c];
        sum_r[c]    <= sum_nxt[c];
        bmax_r[c]   <= bmax_nxt[c];
        wmin_r[c]   <= wmin_nxt[c];
        lo_r[c]     <= lo_nxt[c];
        hi_r[c]     <= hi_nxt[c];
      end
    end
  end

endmodule

FILE: hw/rtl/lscc_queue.sv
// Short snapshot queue between front and back ends.
// Depends on lscc_pkg.
module lscc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  lscc_pkg::push_t push,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output lscc_pkg::snap_t q_data
);
  import lscc_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  snap_t             store_r [QDEPTH];
  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  tail_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_pop;

  assign full    = (count_r == CNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = store_r[head_r];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push.valid) store_r[tail_r] <= push.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push.valid) tail_r <= (tail_r == PTR_W'(QDEPTH - 1)) ? '0 : tail_r + 1'b1;
      if (do_pop) head_r <= (head_r == PTR_W'(QDEPTH - 1)) ? '0 : head_r + 1'b1;
      count_r <= count_r + CNT_W'(push.valid) - CNT_W'(do_pop);
    end
  end

endmodule

FILE: hw/rtl/lscc_back.sv
// Back end: classifies the newest samples, divides the window sums and
// holds the result word in the output register. Depends on lscc_pkg.
module lscc_back #(
  parameter int WINDOW   = 20,
  parameter int CHANNELS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  lscc_pkg::snap_t                 q_data,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lscc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import lscc_pkg::*;

  // floor(x / WINDOW) as (x * RECIP) >> SHIFT, exact for SUM_W-bit x
  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SHIFT + 1;
  localparam longint RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam int PROD_W  = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] res;

  assign pop        = q_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic                is_b;
    logic                is_r;
    logic                is_w;
    logic                any_b;
    logic                any_r;
    logic                any_w;
    logic [PROD_W-1:0]   prod;
    res   = '0;
    any_b = 1'b0;
    any_r = 1'b0;
    any_w = 1'b0;
    for (int c = 0; c < MAXCH; c++) begin
      v    = q_data.newest[c];
      lo   = q_data.lower[c];
      hi   = q_data.upper[c];
      is_b = v < lo;
      is_r = (v >= lo) && (v <= hi);
      is_w = v > hi;
      prod = PROD_W'(q_data.sum[c]) * PROD_W'(RECIP_K);
      if (c < CHANNELS) begin
        // crossed thresholds: black wins, then red
        res[2*c +: 2] = is_b ? COLOR_BLACK : (is_r ? COLOR_RED : COLOR_WHITE);
        res[11 + SAMPLE_W*c +: SAMPLE_W] = prod[SHIFT +: SAMPLE_W];
        any_b = any_b || is_b;
        any_r = any_r || is_r;
        any_w = any_w || is_w;
      end
    end
    res[8]  = any_b;
    res[9]  = any_r;
    res[10] = any_w;
  end

  always_ff @(posedge clk) begin
    if (pop) out_data_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/line_sensor_color_classifier.sv
// Top level of the line sensor colour classifier: register port, front end,
// snapshot queue and back end. Depends on lscc_pkg, lscc_front, lscc_queue, lscc_back.
//
//  port group  role    word
//  in_*        slave   mode in tuser, four samples in tdata
//  out_*       master  colours, flags and averages in tdata
//  cfg_*       APB     lower_margin at 0x0, upper_margin at 0x4
//
// One word per cycle sustained while the queue has room; a word's result reaches
// out_* through the queue (front update and queue write at the accepting edge,
// then classify and divide into the output register).
// The four-entry queue lets the input keep running while the output stalls;
// in_tready drops only when the queue is full.
// Synchronous active-low reset; the ring needs no clearing pass, its valid bits
// are cleared at once.
module line_sensor_color_classifier #(
  parameter int WINDOW   = 20,
  parameter int CHANNELS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // sample_0 [9:0], sample_1 [19:10], sample_2 [29:20], sample_3 [39:30]
  input  logic [lscc_pkg::IN_DATA_W-1:0]   in_tdata,
  // mode [1:0]
  input  logic [lscc_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // color_0..3 [7:0], any_black [8], any_red [9], any_white [10],
  // average_0 [20:11], average_1 [30:21], average_2 [40:31], average_3 [50:41], zero [55:51]
  output logic [lscc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [lscc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [lscc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [lscc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import lscc_pkg::*;

  logic [MARGIN_W-1:0] lower_margin_r;
  logic [MARGIN_W-1:0] upper_margin_r;
  logic                cfg_wr;
  logic                q_full;
  logic                q_valid;
  logic                pop;
  push_t               push;
  snap_t               q_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_UPPER_MARGIN) ?
                      CFG_DATA_W'(upper_margin_r) : CFG_DATA_W'(lower_margin_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_margin_r <= LOWER_MARGIN_RESET;
      upper_margin_r <= UPPER_MARGIN_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_LOWER_MARGIN) lower_margin_r <= cfg_pwdata[MARGIN_W-1:0];
      else upper_margin_r <= cfg_pwdata[MARGIN_W-1:0];
    end
  end

  lscc_front #(.WINDOW(WINDOW), .CHANNELS(CHANNELS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .lower_margin (lower_margin_r),
    .upper_margin (upper_margin_r),
    .q_full       (q_full),
    .push         (push)
  );

  lscc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  lscc_back #(.WINDOW(WINDOW), .CHANNELS(CHANNELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: hw/rtl/lscc_checker.sv
// Port-level checks of the colour classifier, bound to its top level.
// Depends on lscc_pkg and line_sensor_color_classifier.
module lscc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lscc_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import lscc_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  // reset empties the queue and output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not empty after reset");

  // every used channel falls in some band, so at least one flag is always set
  a_some_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8] || out_tdata[9] || out_tdata[10]))
    else $error("no colour flag set");

  // channel 0 colour agrees with its flag
  a_color_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[1:0] == COLOR_BLACK) && out_tdata[8]) ||
                   ((out_tdata[1:0] == COLOR_RED) && out_tdata[9]) ||
                   ((out_tdata[1:0] == COLOR_WHITE) && out_tdata[10]))
    else $error("colour and flag disagree");

  // no colour code three on any channel
  a_color_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3) && (out_tdata[3:2] != 2'd3) &&
                   (out_tdata[5:4] != 2'd3) && (out_tdata[7:6] != 2'd3))
    else $error("invalid colour code");

endmodule

bind line_sensor_color_classifier lscc_checker u_lscc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/line_sensor_color_classifier_tb.sv
// Self-checking bench for the line sensor colour classifier: streams sample words, stalls
// both sides at random, rewrites the margins between phases and checks every result word.
// Depends on lscc_pkg and line_sensor_color_classifier.
module line_sensor_color_classifier_tb;
  import lscc_pkg::*;

  localparam int WIN           = 20;
  localparam int NCH           = 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASES        = 6;
  localparam int PHASE_WORDS   = 158;

  typedef logic [MAXCH-1:0][SAMPLE_W-1:0] sample_set_t;

  // out_tdata layout, lowest field last
  typedef struct packed {
    logic [4:0]                     pad;
    logic [MAXCH-1:0][SAMPLE_W-1:0] average;
    logic                           any_white;
    logic                           any_red;
    logic                           any_black;
    logic [MAXCH-1:0][1:0]          color;
  } result_t;

  class classifier_model;
    logic [MARGIN_W-1:0] lower_margin;
    logic [MARGIN_W-1:0] upper_margin;
    logic [SAMPLE_W-1:0] ring [NCH][WIN];
    int                  newest_slot;
    int                  sums [NCH];
    int                  black_max [NCH];
    int                  white_min [NCH];
    int                  lower_thr [NCH];
    int                  upper_thr [NCH];
    result_t             predicted_classes [$];
    int                  mismatches;
    int                  results_seen;

    function new();
      lower_margin = LOWER_MARGIN_RESET;
      upper_margin = UPPER_MARGIN_RESET;
      newest_slot  = WIN - 1;
      for (int c = 0; c < NCH; c++) begin
        for (int k = 0; k < WIN; k++) ring[c][k] = SAMPLE_RESET;
        sums[c]      = WIN * int'(SAMPLE_RESET);
        black_max[c] = 0;
        white_min[c] = int'(SAMPLE_MAX);
        lower_thr[c] = int'(LOWER_RESET[c]);
        upper_thr[c] = int'(UPPER_RESET[c]);
      end
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_margin(logic idx, logic [MARGIN_W-1:0] v);
      if (idx == REG_LOWER_MARGIN) begin
        lower_margin = v;
      end else begin
        upper_margin = v;
      end
    endfunction

    function int clamp10(int v);
      if (v < 0) return 0;
      if (v > 1023) return 1023;
      return v;
    endfunction

    function void classify_word(mode_t mode, sample_set_t s);
      result_t r;
      int      v;
      int      span;
      case (mode)
        MODE_SAMPLE: begin
          newest_slot = (newest_slot >= WIN - 1) ? 0 : newest_slot + 1;
          for (int c = 0; c < NCH; c++) begin
            sums[c] = sums[c] - int'(ring[c][newest_slot]) + int'(s[c]);
            ring[c][newest_slot] = s[c];
          end
        end
        MODE_BLACK: begin
          for (int c = 0; c < NCH; c++)
            if (int'(s[c]) > black_max[c]) black_max[c] = int'(s[c]);
        end
        MODE_WHITE: begin
          for (int c = 0; c < NCH; c++)
            if (int'(s[c]) < white_min[c]) white_min[c] = int'(s[c]);
        end
        default: begin
          // span may be negative; >>> floors the Q8 product
          for (int c = 0; c < NCH; c++) begin
            span = white_min[c] - black_max[c];
            lower_thr[c] = clamp10(black_max[c] + ((int'(lower_margin) * span) >>> 8));
            upper_thr[c] = clamp10(white_min[c] - ((int'(upper_margin) * span) >>> 8));
          end
        end
      endcase
      r = '0;
      for (int c = 0; c < NCH; c++) begin
        v = int'(ring[c][newest_slot]);
        // crossed thresholds: black wins, flags stay independent
        if (v < lower_thr[c]) r.color[c] = COLOR_BLACK;
        else if (v <= upper_thr[c]) r.color[c] = COLOR_RED;
        else r.color[c] = COLOR_WHITE;
        if (v < lower_thr[c]) r.any_black = 1'b1;
        if (v >= lower_thr[c] && v <= upper_thr[c]) r.any_red = 1'b1;
        if (v > upper_thr[c]) r.any_white = 1'b1;
        r.average[c] = SAMPLE_W'(clamp10(sums[c] / WIN));
      end
      predicted_classes.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (predicted_classes.size() == 0) begin
        $error("result word %h arrived with nothing expected", got);
        mismatches++;
        return;
      end
      want = predicted_classes.pop_front();
      for (int c = 0; c < NCH; c++) begin
        if (got.color[c] !== want.color[c]) begin
          $error("color_%0d: expected %0d, got %0d", c, want.color[c], got.color[c]);
          mismatches++;
        end
        if (got.average[c] !== want.average[c]) begin
          $error("average_%0d: expected %0d, got %0d", c, want.average[c], got.average[c]);
          mismatches++;
        end
      end
      if (got.any_black !== want.any_black) begin
        $error("any_black: expected %0d, got %0d", want.any_black, got.any_black);
        mismatches++;
      end
      if (got.any_red !== want.any_red) begin
        $error("any_red: expected %0d, got %0d", want.any_red, got.any_red);
        mismatches++;
      end
      if (got.any_white !== want.any_white) begin
        $error("any_white: expected %0d, got %0d", want.any_white, got.any_white);
        mismatches++;
      end
    endfunction

    function int pending();
      return predicted_classes.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  classifier_model sb;
  int              cycle_count = 0;
  int              words_sent = 0;
  int              margin_writes = 0;
  bit              steady_sender = 0;

  line_sensor_color_classifier #(
    .WINDOW  (WIN),
    .CHANNELS(NCH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("line_sensor_color_classifier_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(result_t'(out_tdata));
  end

  // result side: mostly short ready runs and short stalls, now and then a long stall or a long free run
  initial begin
    int r;
    int hold;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_tready <= 1'b1;
        hold = $urandom_range(1, 12);
      end else if (r < 66) begin
        out_tready <= 1'b1;
        hold = $urandom_range(80, 200);
      end else if (r < 94) begin
        out_tready <= 1'b0;
        hold = $urandom_range(1, 3);
      end else begin
        out_tready <= 1'b0;
        hold = $urandom_range(15, 50);
      end
      repeat (hold) @(posedge clk);
    end
  end

  function automatic int sender_gap();
    int r;
    if (steady_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  function automatic sample_set_t ranged_set(int lo, int hi);
    sample_set_t s;
    for (int c = 0; c < NCH; c++) s[c] = SAMPLE_W'($urandom_range(lo, hi));
    return s;
  endfunction

  // samples clustered on the current thresholds so all three colours turn up
  function automatic sample_set_t line_set();
    sample_set_t s;
    int          v;
    int          r;
    for (int c = 0; c < NCH; c++) begin
      r = $urandom_range(0, 9);
      if (r < 3) v = sb.lower_thr[c] + $urandom_range(0, 6) - 3;
      else if (r < 6) v = sb.upper_thr[c] + $urandom_range(0, 6) - 3;
      else if (r < 7) v = $urandom_range(0, 1) ? 1023 : 0;
      else v = $urandom_range(0, 1023);
      s[c] = SAMPLE_W'(sb.clamp10(v));
    end
    return s;
  endfunction

  function automatic int pick_margin();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r < 4) return 256;
    if (r < 5) return 511;
    if (r < 6) return $urandom_range(257, 511);
    return $urandom_range(0, 256);
  endfunction

  task automatic send_word(mode_t m, sample_set_t s);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    sb.classify_word(m, s);
    words_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the input off until every result is back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_margin(logic idx, int margin);
    logic [CFG_DATA_W-1:0] value;
    value = $urandom;
    value[MARGIN_W-1:0] = MARGIN_W'(margin);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_margin(idx, value[MARGIN_W-1:0]);
    margin_writes++;
    @(posedge clk);
  endtask

  initial begin
    int r;
    int n;
    int phase_end;
    int pause_at;
    bit paused;
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: extremes, exact threshold hits either side
    send_word(MODE_SAMPLE, {10'd0, 10'd0, 10'd0, 10'd0});
    send_word(MODE_SAMPLE, {10'd1023, 10'd1023, 10'd1023, 10'd1023});
    send_word(MODE_SAMPLE, {10'd124, 10'd441, 10'd550, 10'd229});
    send_word(MODE_SAMPLE, {10'd125, 10'd440, 10'd551, 10'd228});
    send_word(MODE_BLACK, {10'd100, 10'd150, 10'd200, 10'd300});
    send_word(MODE_BLACK, {10'd0, 10'd0, 10'd0, 10'd0});
    send_word(MODE_WHITE, {10'd650, 10'd700, 10'd900, 10'd800});
    send_word(MODE_WHITE, {10'd1023, 10'd1023, 10'd1023, 10'd1023});
    send_word(MODE_THRESH, ranged_set(0, 1023));
    repeat (3) send_word(MODE_SAMPLE, line_set());
    // full-span margins cross the thresholds: lower lands on white, upper on black
    settle();
    write_margin(REG_LOWER_MARGIN, 256);
    write_margin(REG_UPPER_MARGIN, 256);
    send_word(MODE_THRESH, ranged_set(0, 1023));
    send_word(MODE_SAMPLE, {10'd400, 10'd400, 10'd500, 10'd500});
    // margins above one push thresholds out of range
    settle();
    write_margin(REG_LOWER_MARGIN, 511);
    write_margin(REG_UPPER_MARGIN, 0);
    send_word(MODE_THRESH, ranged_set(0, 1023));
    send_word(MODE_SAMPLE, {10'd600, 10'd0, 10'd1022, 10'd1023});
    settle();
    write_margin(REG_LOWER_MARGIN, 0);
    write_margin(REG_UPPER_MARGIN, 511);
    send_word(MODE_THRESH, ranged_set(0, 1023));
    repeat (2) send_word(MODE_SAMPLE, line_set());

    // random phases: calibration, threshold computation and long runs over the line, mixed at random
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_margin(REG_LOWER_MARGIN, pick_margin());
      write_margin(REG_UPPER_MARGIN, pick_margin());
      phase_end = words_sent + PHASE_WORDS;
      pause_at  = words_sent + $urandom_range(20, PHASE_WORDS - 20);
      paused    = 0;
      while (words_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          n = $urandom_range(1, 4);
          repeat (n) send_word(MODE_BLACK, ranged_set(20, 420));
          n = $urandom_range(1, 4);
          repeat (n) send_word(MODE_WHITE, ranged_set(560, 1023));
          send_word(MODE_THRESH, ranged_set(0, 1023));
        end else if (r < 14) begin
          send_word($urandom_range(0, 1) ? MODE_THRESH : MODE_SAMPLE, ranged_set(0, 1023));
        end else if (r < 16) begin
          send_word(MODE_BLACK, ranged_set(0, 420));
        end else if (r < 18) begin
          send_word(MODE_WHITE, ranged_set(560, 1023));
        end else begin
          send_word(MODE_SAMPLE, line_set());
        end
        if (!paused && words_sent >= pause_at) begin
          settle();
          paused = 1;
        end
        if ($urandom_range(0, 99) < 3) steady_sender = !steady_sender;
      end
    end

    // black above white on some channels: negative span
    steady_sender = 0;
    settle();
    write_margin(REG_LOWER_MARGIN, 128);
    write_margin(REG_UPPER_MARGIN, 64);
    send_word(MODE_BLACK, {10'd0, 10'd0, 10'd900, 10'd1023});
    send_word(MODE_WHITE, {10'd1023, 10'd1023, 10'd100, 10'd0});
    send_word(MODE_THRESH, ranged_set(0, 1023));
    repeat (3) send_word(MODE_SAMPLE, line_set());
    settle();
    write_margin(REG_LOWER_MARGIN, 511);
    write_margin(REG_UPPER_MARGIN, 511);
    send_word(MODE_THRESH, ranged_set(0, 1023));
    repeat (3) send_word(MODE_SAMPLE, ranged_set(0, 1023));

    settle();
    repeat (10) @(posedge clk);
    $display("%0d words sent, %0d results checked, %0d margin writes", words_sent,
             sb.results_seen, margin_writes);
    $display("covered all modes, crossed, clamped and negative-span thresholds, both-side stalls");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("line_sensor_color_classifier_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("line_sensor_color_classifier_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lscc_pkg.sv
hw/rtl/lscc_front.sv
hw/rtl/lscc_queue.sv
hw/rtl/lscc_back.sv
hw/rtl/line_sensor_color_classifier.sv
hw/rtl/lscc_checker.sv
test/line_sensor_color_classifier_tb.sv
